[rtl/bfs_pkg.sv]
// Package for the bounded queue with search: widths, command and status codes,
// and the request record passed to the wait estimator.
// No dependencies.
package bfs_pkg;

    // Queue geometry and field widths.
    localparam int DEPTH   = 64;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ID_W    = 16;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int CAP_W   = 7;
    localparam int MIN_W   = 8;
    localparam int WAIT_W  = 14;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 8;

    // Dividend n + cap - 1, quotient and product widths of the wait estimator.
    localparam int DIVD_W  = CNT_W + 1;
    localparam int PROD_W  = DIVD_W + MIN_W;

    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [WAIT_W-1:0] WAIT_MAX   = {WAIT_W{1'b1}};

    // Commands carried on the input side.
    localparam logic [CMD_W-1:0] CMD_ENQ   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MINUTES  = 2'd1;

    // Start request for the wait estimator.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
        logic [CAP_W-1:0] capacity;
        logic [MIN_W-1:0] minutes;
    } wait_req_t;

    // Write request into the identifier store.
    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        logic [ID_W-1:0]  data;
    } store_wr_t;

endpackage

[rtl/bfs_store.sv]
// Identifier store: one write port and one read port with registered read data.
// Depends on bfs_pkg.
module bfs_store
    import bfs_pkg::*;
(
    input  logic             clk,
    input  store_wr_t        wr,
    input  logic             rd_en,
    input  logic [PTR_W-1:0] rd_addr,
    output logic [ID_W-1:0]  rd_data
);

    logic [ID_W-1:0] mem [DEPTH];
    logic [ID_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port: the data is registered and appears in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/bfs_wait.sv]
// Wait estimator: ceil(count / capacity) by a bit-serial restoring divider,
// then one multiply by the minutes per round, saturated. Depends on bfs_pkg.
module bfs_wait
    import bfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  wait_req_t         req,
    output logic              done,
    output logic [WAIT_W-1:0] wait_minutes
);

    localparam int STEP_W = $clog2(DIVD_W);

    localparam logic [1:0] W_IDLE = 2'd0;
    localparam logic [1:0] W_DIV  = 2'd1;
    localparam logic [1:0] W_MUL  = 2'd2;
    localparam logic [1:0] W_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIVD_W-1:0] dvd_reg, dvd_next;
    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quot_reg, quot_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [MIN_W-1:0]  min_reg, min_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    logic [DIVD_W-1:0] rem_sh;
    logic              rem_ge;

    // One restoring division step: shift in the next dividend bit and subtract if it fits.
    always_comb
    begin
        rem_sh = {rem_reg[DIVD_W-2:0], dvd_reg[DIVD_W-1]};
        rem_ge = (rem_sh >= DIVD_W'(cap_reg));
    end

    // Sequencer of the shared divide step and the final multiply.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        cap_next   = cap_reg;
        min_next   = min_reg;
        prod_next  = prod_reg;
        case (state_reg)
            W_IDLE:
            begin
                if (req.start)
                begin
                    cap_next = req.capacity;
                    min_next = req.minutes;
                    if (req.count == '0 || req.capacity == '0)
                    begin
                        prod_next  = '0;
                        state_next = W_DONE;
                    end
                    else
                    begin
                        dvd_next   = DIVD_W'(req.count) + DIVD_W'(req.capacity) - DIVD_W'(1);
                        rem_next   = '0;
                        quot_next  = '0;
                        step_next  = '0;
                        state_next = W_DIV;
                    end
                end
            end
            W_DIV:
            begin
                rem_next  = rem_ge ? (rem_sh - DIVD_W'(cap_reg)) : rem_sh;
                quot_next = {quot_reg[DIVD_W-2:0], rem_ge};
                dvd_next  = {dvd_reg[DIVD_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIVD_W - 1))
                begin
                    state_next = W_MUL;
                end
            end
            W_MUL:
            begin
                prod_next  = PROD_W'(quot_reg) * PROD_W'(min_reg);
                state_next = W_DONE;
            end
            W_DONE:
            begin
                state_next = W_IDLE;
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        cap_reg  <= cap_next;
        min_reg  <= min_next;
        prod_reg <= prod_next;
    end

    // Result with saturation.
    assign done         = (state_reg == W_DONE);
    assign wait_minutes = (prod_reg > PROD_W'(WAIT_MAX)) ? WAIT_MAX : prod_reg[WAIT_W-1:0];

endmodule

[rtl/bounded_fifo_with_search.sv]
// Bounded queue of 64 16-bit identifiers with enqueue, dequeue, peek, find and clear.
// One item is taken at a time: s_tready is high only while the block is idle, and
// the result waits in an output register until m_tready takes it. The time from one
// accepted item to the next is set by the wait estimator, an 8-step bit-serial divider
// followed by one multiply, both skipped when the count or capacity is zero;
// dequeue and peek add a store read, and find is also set by the single read port
// of the store, which the search walks one entry per cycle.
// Depends on bfs_pkg, bfs_store and bfs_wait.
module bounded_fifo_with_search
    import bfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Input items.
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,    // [15:0] item_id
    input  logic [2:0]         s_tuser,    // [2:0] cmd
    // Result items.
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,    // [1:0] status, [17:2] out_id, [18] found,
                                           // [25:19] position, [32:26] count,
                                           // [46:33] wait_minutes, [47] zero
    // Configuration writes.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FETCH  = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_WAIT   = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]  cidx_reg, cidx_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic [MIN_W-1:0]  minutes_reg;

    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  position_reg, position_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;

    logic              in_acc;
    store_wr_t         st_wr;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [ID_W-1:0]   rd_data;
    wait_req_t         wreq;
    logic              w_done;
    logic [WAIT_W-1:0] w_minutes;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Store reads: the head on acceptance, the scan pointer during a search.
    assign rd_en   = in_acc || (state_reg == ST_SEARCH);
    assign rd_addr = (state_reg == ST_IDLE) ? head_reg : scan_reg;

    // Command sequencer.
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        cidx_next     = cidx_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        status_next   = status_reg;
        out_id_next   = out_id_reg;
        found_next    = found_reg;
        position_next = position_reg;
        wait_next     = wait_reg;
        st_wr.en      = 1'b0;
        st_wr.addr    = tail_reg;
        st_wr.data    = s_tdata;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next      = s_tuser;
                    id_next       = s_tdata;
                    status_next   = STAT_OK;
                    out_id_next   = '0;
                    found_next    = 1'b0;
                    position_next = '0;
                    state_next    = ST_WAIT;
                    case (s_tuser)
                        CMD_ENQ:
                        begin
                            if (count_reg >= FULL_COUNT)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                st_wr.en   = 1'b1;
                                tail_next  = tail_reg + PTR_W'(1);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DEQ, CMD_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (count_reg != '0)
                            begin
                                scan_next  = head_reg + PTR_W'(1);
                                cidx_next  = '0;
                                state_next = ST_SEARCH;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_WAIT;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                out_id_next = rd_data;
                if (cmd_reg == CMD_DEQ)
                begin
                    head_next  = head_reg + PTR_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = ST_WAIT;
            end
            ST_SEARCH:
            begin
                // Compare the entry read last cycle while the next one is read.
                if (rd_data == id_reg)
                begin
                    found_next    = 1'b1;
                    position_next = cidx_reg + CNT_W'(1);
                    state_next    = ST_WAIT;
                end
                else if (cidx_reg + CNT_W'(1) == count_reg)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    scan_next = scan_reg + PTR_W'(1);
                    cidx_next = cidx_reg + CNT_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (w_done)
                begin
                    wait_next  = w_minutes;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Start the estimator with the count left by the command.
    always_comb
    begin
        wreq.start    = (state_reg != ST_WAIT) && (state_next == ST_WAIT);
        wreq.count    = count_next;
        wreq.capacity = capacity_reg;
        wreq.minutes  = minutes_reg;
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            scan_reg     <= '0;
            cidx_reg     <= '0;
            cmd_reg      <= CMD_ENQ;
            capacity_reg <= CAP_W'(10);
            minutes_reg  <= MIN_W'(5);
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            cidx_reg  <= cidx_next;
            cmd_reg   <= cmd_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CAPACITY)
                begin
                    capacity_reg <= cfg_data[CAP_W-1:0];
                end
                else if (cfg_index == REG_MINUTES)
                begin
                    minutes_reg <= cfg_data[MIN_W-1:0];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        status_reg   <= status_next;
        out_id_reg   <= out_id_next;
        found_reg    <= found_next;
        position_reg <= position_next;
        wait_reg     <= wait_next;
    end

    bfs_store u_store
    (
        .clk     (clk),
        .wr      (st_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bfs_wait u_wait
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (wreq),
        .done         (w_done),
        .wait_minutes (w_minutes)
    );

    // Result item.
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {1'b0, wait_reg, count_reg, position_reg, found_reg,
                       out_id_reg, status_reg};

    // The queue never holds more than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("item count exceeds queue depth");

    // Input and output sides are never open together.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    // A found position lies within the queue.
    a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && found_reg) |-> (position_reg != '0 && position_reg <= count_reg))
        else $error("found position outside the queue");

    // The estimator finishes only while the sequencer waits for it.
    a_wait_done: assert property (@(posedge clk) disable iff (!rst_n)
        w_done |-> (state_reg == ST_WAIT))
        else $error("wait estimate finished outside the wait state");

    // A full enqueue leaves the count unchanged.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser == CMD_ENQ && count_reg == FULL_COUNT) |=>
        (count_reg == FULL_COUNT && status_reg == STAT_FULL))
        else $error("enqueue on a full queue changed the count");

endmodule

[bench/testbench.sv]
// Self-checking bench for the bounded identifier queue with search.
// A directed table, then random command mixes under several register settings,
// each result compared with an in-bench queue predictor. Depends on bfs_pkg and the RTL.
module testbench;
    import bfs_pkg::*;

    // Run shape.
    localparam int unsigned PHASE_ITEMS   = 230;
    localparam int unsigned PHASE_COUNT   = 8;
    localparam int unsigned DIRECTED_ROWS = 23;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned DRAIN_CYCLES  = 100;
    localparam int unsigned HOLD_AFTER    = 300;
    localparam int unsigned HOLD_CYCLES   = 400;
    // Share of enqueue plus dequeue in the random mix; peek, find, clear and
    // unknown commands take the remaining percentage points.
    localparam int unsigned MIX_QUEUE_PCT = 74;

    // Command codes the block treats as no-ops, and register indexes it ignores.
    localparam logic [CMD_W-1:0]  CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_RSVD_MID   = 3'd6;
    localparam logic [CMD_W-1:0]  CMD_RSVD_LAST  = 3'd7;
    localparam logic [CIDX_W-1:0] REG_SPARE_A    = 2'd2;
    localparam logic [CIDX_W-1:0] REG_SPARE_B    = 2'd3;

    // One result item, field by field.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   out_id;
        logic              found;
        logic [CNT_W-1:0]  position;
        logic [CNT_W-1:0]  count;
        logic [WAIT_W-1:0] wait_minutes;
    } queue_result_t;

    // One row of the directed table; the result is used only when typed is set.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        logic             typed;
        queue_result_t    result;
    } directed_row_t;

    // One random phase: register settings and command mix.
    typedef struct packed {
        logic [CDATA_W-1:0] cap_data;
        logic [CDATA_W-1:0] min_data;
        logic [7:0]         enq_pct;
        logic               no_idle;
        logic               random_cfg;
        logic               spare_writes;
    } phase_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata = '0;
    logic [2:0]         s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [47:0]        m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [CDATA_W-1:0] cfg_data = '0;

    // Predictor state: queued identifiers and the register copies.
    logic [ID_W-1:0]  held_ids[$];
    logic [CAP_W-1:0] capacity_setting = CAP_W'(10);
    logic [MIN_W-1:0] minutes_setting = MIN_W'(5);

    queue_result_t expected_results[$];
    int unsigned   mismatch_count = 0;
    int unsigned   results_taken = 0;
    int unsigned   cycle_count = 0;
    bit            no_idle = 1'b0;

    // Directed rows run with the reset settings: 10 per round, 5 minutes.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        {CMD_PEEK,       16'h0000, 1'b1, {STAT_EMPTY, 16'h0, 1'b0, 7'd0, 7'd0, 14'd0}},
        {CMD_DEQ,        16'h0000, 1'b1, {STAT_EMPTY, 16'h0, 1'b0, 7'd0, 7'd0, 14'd0}},
        {CMD_FIND,       16'hFFFF, 1'b1, {STAT_OK,    16'h0, 1'b0, 7'd0, 7'd0, 14'd0}},
        {CMD_ENQ,        16'h0000, 1'b1, {STAT_OK,    16'h0, 1'b0, 7'd0, 7'd1, 14'd5}},
        {CMD_ENQ,        16'hFFFF, 1'b1, {STAT_OK,    16'h0, 1'b0, 7'd0, 7'd2, 14'd5}},
        {CMD_ENQ,        16'h5A5A, 1'b0, 47'h0},
        {CMD_ENQ,        16'hA5A5, 1'b0, 47'h0},
        {CMD_FIND,       16'hFFFF, 1'b0, 47'h0},
        {CMD_FIND,       16'h0000, 1'b0, 47'h0},
        {CMD_FIND,       16'h1234, 1'b0, 47'h0},
        {CMD_PEEK,       16'hFFFF, 1'b0, 47'h0},
        {CMD_DEQ,        16'hFFFF, 1'b0, 47'h0},
        {CMD_FIND,       16'h0000, 1'b0, 47'h0},
        {CMD_RSVD_FIRST, 16'hFFFF, 1'b0, 47'h0},
        {CMD_RSVD_MID,   16'h0000, 1'b0, 47'h0},
        {CMD_RSVD_LAST,  16'hA5A5, 1'b0, 47'h0},
        {CMD_ENQ,        16'hFFFF, 1'b0, 47'h0},
        {CMD_FIND,       16'hFFFF, 1'b0, 47'h0},
        {CMD_DEQ,        16'h0000, 1'b0, 47'h0},
        {CMD_CLEAR,      16'h0000, 1'b1, {STAT_OK,    16'h0, 1'b0, 7'd0, 7'd0, 14'd0}},
        {CMD_PEEK,       16'h0000, 1'b1, {STAT_EMPTY, 16'h0, 1'b0, 7'd0, 7'd0, 14'd0}},
        {CMD_CLEAR,      16'hFFFF, 1'b1, {STAT_OK,    16'h0, 1'b0, 7'd0, 7'd0, 14'd0}},
        {CMD_ENQ,        16'h8001, 1'b1, {STAT_OK,    16'h0, 1'b0, 7'd0, 7'd1, 14'd5}}
    };

    // Settings cover a capacity of 0, 1, 64 and 127 and minutes of 0 and 255.
    phase_t phases [PHASE_COUNT] = '{
        {8'd1,   8'd255, 8'd55, 1'b0, 1'b0, 1'b0},
        {8'd64,  8'd255, 8'd37, 1'b1, 1'b0, 1'b0},
        {8'd0,   8'd200, 8'd25, 1'b0, 1'b0, 1'b0},
        {8'd127, 8'd1,   8'd55, 1'b0, 1'b0, 1'b1},
        {8'd7,   8'd0,   8'd37, 1'b0, 1'b0, 1'b0},
        {8'd0,   8'd0,   8'd25, 1'b1, 1'b1, 1'b0},
        {8'd3,   8'd17,  8'd55, 1'b0, 1'b0, 1'b0},
        {8'd0,   8'd0,   8'd37, 1'b0, 1'b1, 1'b0}
    };

    bounded_fifo_with_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a period of 8.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Wait estimate: rounds needed for n items times the minutes per round.
    function automatic logic [WAIT_W-1:0] wait_for_count(input int unsigned n);
        int unsigned rounds;
        int unsigned total;
        if (n == 0 || capacity_setting == 0)
            return '0;
        rounds = (n + capacity_setting - 1) / capacity_setting;
        total = rounds * minutes_setting;
        if (total > WAIT_MAX)
            return WAIT_MAX;
        return WAIT_W'(total);
    endfunction

    // Applies one command to the predicted queue and returns its result.
    function automatic queue_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [ID_W-1:0] id);
        queue_result_t r;
        r = '0;
        case (cmd)
            CMD_ENQ:
            begin
                if (held_ids.size() >= DEPTH)
                    r.status = STAT_FULL;
                else
                    held_ids.push_back(id);
            end
            CMD_DEQ, CMD_PEEK:
            begin
                if (held_ids.size() == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.out_id = held_ids[0];
                    if (cmd == CMD_DEQ)
                        void'(held_ids.pop_front());
                end
            end
            CMD_FIND:
            begin
                // The first match counted from the head wins.
                for (int i = 0; i < held_ids.size(); i++)
                begin
                    if (!r.found && held_ids[i] == id)
                    begin
                        r.found = 1'b1;
                        r.position = CNT_W'(i + 1);
                    end
                end
            end
            CMD_CLEAR:
                held_ids.delete();
            default:
                ;
        endcase
        r.count = CNT_W'(held_ids.size());
        r.wait_minutes = wait_for_count(held_ids.size());
        return r;
    endfunction

    // Idle length: mostly none, sometimes short, now and then long.
    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Identifier for a random item: finds mostly look for something queued,
    // and a small pool of values makes duplicates common.
    function automatic logic [ID_W-1:0] pick_id(input logic [CMD_W-1:0] cmd);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (cmd == CMD_FIND && held_ids.size() != 0 && roll < 70)
            return held_ids[$urandom_range(0, held_ids.size() - 1)];
        if (roll < 80)
            return ID_W'($urandom);
        if (roll < 92)
            return ID_W'($urandom_range(0, 7));
        return roll[0] ? '1 : '0;
    endfunction

    // Offers one item, waits for it to be taken and records what should come back.
    task automatic issue_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input logic typed, input queue_result_t typed_result);
        int unsigned   gap;
        queue_result_t predicted;
        gap = draw_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= id;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_command(cmd, id);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    // One register write; the caller lowers cfg_valid after its last write.
    task automatic write_register(input logic [CIDX_W-1:0] index,
                                  input logic [CDATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == REG_CAPACITY)
            capacity_setting = data[CAP_W-1:0];
        else if (index == REG_MINUTES)
            minutes_setting = data;
    endtask

    // Stops offering and waits until every outstanding result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // A random command mix; enq_pct sets whether the queue tends to fill or drain.
    task automatic run_random_phase(input int unsigned enq_pct);
        logic [CMD_W-1:0] cmd;
        int unsigned      roll;
        int unsigned      queue_pct;
        queue_pct = MIX_QUEUE_PCT;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < enq_pct)
                cmd = CMD_ENQ;
            else if (roll < queue_pct)
                cmd = CMD_DEQ;
            else if (roll < queue_pct + 8)
                cmd = CMD_PEEK;
            else if (roll < queue_pct + 22)
                cmd = CMD_FIND;
            else if (roll < queue_pct + 23)
                cmd = CMD_CLEAR;
            else
                cmd = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
            issue_item(cmd, pick_id(cmd), 1'b0, '0);
        end
    endtask

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compares a taken result item with the oldest expectation.
    task automatic check_result(input logic [47:0] word);
        queue_result_t want;
        results_taken++;
        if (expected_results.size() == 0)
        begin
            $error("result item with no expectation waiting: 0x%h", word);
            mismatch_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            compare_field("status", want.status, word[1:0]);
            compare_field("out_id", want.out_id, word[17:2]);
            compare_field("found", want.found, word[18]);
            compare_field("position", want.position, word[25:19]);
            compare_field("count", want.count, word[32:26]);
            compare_field("wait_minutes", want.wait_minutes, word[46:33]);
            compare_field("padding", 0, word[47]);
        end
    endtask

    // Result side: random stalls, and one long hold-off so that the block backs up.
    initial
    begin : result_sink
        int unsigned stall;
        bit          held_off;
        stall = 0;
        held_off = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (!held_off && results_taken == HOLD_AFTER)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (stall != 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                stall = draw_gap();
                m_tready <= (stall == 0);
            end
        end
    end

    // Stimulus: reset, directed table, then the random phases.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_item(directed_rows[i].cmd, directed_rows[i].id,
                       directed_rows[i].typed, directed_rows[i].result);

        foreach (phases[p])
        begin
            drain_results();
            no_idle = phases[p].no_idle;
            if (phases[p].random_cfg)
            begin
                write_register(REG_CAPACITY, CDATA_W'($urandom_range(0, 255)));
                write_register(REG_MINUTES, CDATA_W'($urandom_range(0, 255)));
            end
            else
            begin
                write_register(REG_CAPACITY, phases[p].cap_data);
                write_register(REG_MINUTES, phases[p].min_data);
            end
            // Writes to unused indexes must leave both settings alone.
            if (phases[p].spare_writes)
            begin
                write_register(REG_SPARE_A, CDATA_W'($urandom_range(0, 255)));
                write_register(REG_SPARE_B, CDATA_W'($urandom_range(0, 255)));
            end
            cfg_valid <= 1'b0;
            run_random_phase(phases[p].enq_pct);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
rtl/bfs_pkg.sv
rtl/bfs_store.sv
rtl/bfs_wait.sv
rtl/bounded_fifo_with_search.sv
bench/testbench.sv
